// File: design/nma_pkg.sv
// nma_pkg: shared widths, types, register codes and the medoid slot lookup
// for the nearest-medoid assignment block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nma_pkg;

  localparam int MAX_SLOTS       = 4;
  localparam int SLOT_W          = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W           = SLOT_W + 1;
  localparam int OUT_SLOT_W      = 2;
  localparam int IDX_W           = 10;
  localparam int DIST_W          = 32;
  localparam int ERR_W           = 48;
  localparam int NCL_W           = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 10;
  localparam int NUM_MEDOID_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEDOID_BASE  = CFG_IDX_W'(1);
  localparam logic [NCL_W-1:0]     NCL_RESET        = NCL_W'(2);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [ERR_W-1:0]  err_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam dist_t DIST_ONES = {DIST_W{1'b1}};
  localparam dist_t DIST_SAT  = {{(DIST_W-1){1'b1}}, 1'b0};
  localparam err_t  ERR_MAX   = {ERR_W{1'b1}};

  typedef struct packed {
    cnt_t                   active;
    idx_t [MAX_SLOTS-1:0]   medoid;
  } cfg_t;

  typedef struct packed {
    idx_t  row_index;
    idx_t  column_index;
    dist_t distance;
    logic  row_end;
    logic  pass_end;
  } item_t;

  typedef struct packed {
    logic  hit;
    slot_t slot;
  } match_t;

  // End-of-row summary from the running minimum to the error accumulator
  typedef struct packed {
    logic  fire;
    idx_t  point;
    logic  self_hit;
    slot_t self_slot;
    logic  has_best;
    slot_t best_slot;
    dist_t best_dist;
    logic  pass_end;
  } row_sum_t;

  typedef struct packed {
    idx_t                  point_index;
    logic [OUT_SLOT_W-1:0] assigned_slot;
    dist_t                 added_error;
    logic                  is_medoid;
    err_t                  slot_error;
    err_t                  total_error;
    logic                  pass_done;
  } res_t;

  // Lowest active slot whose medoid index equals key
  function automatic match_t find_slot(cfg_t c, idx_t key);
    match_t m;
    m = '0;
    for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
      if ((CNT_W'(s) < c.active) && (c.medoid[s] == key)) begin
        m.hit  = 1'b1;
        m.slot = SLOT_W'(s);
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// File: design/nma_ifs.sv
// Handshake channels of the nearest-medoid assignment block: input words,
// result words and configuration writes. Depends on nma_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface nma_item_if;
  import nma_pkg::*;
  logic  valid;
  logic  ready;
  idx_t  row_index;
  idx_t  column_index;
  dist_t distance;
  logic  row_end;
  logic  pass_end;
  modport source(output valid, row_index, column_index, distance, row_end, pass_end,
                 input ready);
  modport sink(input valid, row_index, column_index, distance, row_end, pass_end,
               output ready);
endinterface

interface nma_result_if;
  import nma_pkg::*;
  logic                  valid;
  logic                  ready;
  idx_t                  point_index;
  logic [OUT_SLOT_W-1:0] assigned_slot;
  dist_t                 added_error;
  logic                  is_medoid;
  err_t                  slot_error;
  err_t                  total_error;
  logic                  pass_done;
  modport source(output valid, point_index, assigned_slot, added_error, is_medoid,
                 slot_error, total_error, pass_done, input ready);
  modport sink(input valid, point_index, assigned_slot, added_error, is_medoid,
               slot_error, total_error, pass_done, output ready);
endinterface

interface nma_cfg_if;
  import nma_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/nma_cfg_regs.sv
// nma_cfg_regs: slot count and medoid index registers with the clamped
// active slot count. Depends on nma_pkg and nma_cfg_if.
`timescale 1ns / 1ps
`default_nettype none
module nma_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  nma_cfg_if.sink           cfg,
  output nma_pkg::cfg_t     cfg_out
);
  import nma_pkg::*;

  logic [NCL_W-1:0]     num_clusters;
  idx_t [MAX_SLOTS-1:0] medoid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= NCL_RESET;
      for (int s = 0; s < MAX_SLOTS; s++) begin
        medoid[s] <= IDX_W'(s);
      end
    end else if (cfg.valid) begin
      if (cfg.index == REG_NUM_CLUSTERS) begin
        num_clusters <= cfg.data[NCL_W-1:0];
      end
      for (int s = 0; s < MAX_SLOTS; s++) begin
        if (s < NUM_MEDOID_REGS && cfg.index == CFG_IDX_W'(int'(REG_MEDOID_BASE) + s)) begin
          medoid[s] <= cfg.data[IDX_W-1:0];
        end
      end
    end
  end

  // Zero acts as one slot, anything above the slot count as all slots
  always_comb begin
    cfg_out.medoid = medoid;
    if (num_clusters == '0) begin
      cfg_out.active = CNT_W'(1);
    end else if (int'(num_clusters) > MAX_SLOTS) begin
      cfg_out.active = CNT_W'(MAX_SLOTS);
    end else begin
      cfg_out.active = CNT_W'(num_clusters);
    end
  end
endmodule
`default_nettype wire

// File: design/nma_row_min.sv
// nma_row_min: running minimum over the medoid columns of one distance row,
// plus the medoid lookup of the row's own point. Depends on nma_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nma_row_min (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         proc,
  input  nma_pkg::item_t    item,
  input  nma_pkg::cfg_t     cfg,
  output nma_pkg::row_sum_t sum
);
  import nma_pkg::*;

  dist_t  best_distance;
  slot_t  best_slot;
  logic   row_has_best;

  dist_t  cur_dist;
  match_t col_m;
  match_t self_m;
  logic   take;
  dist_t  best_distance_next;
  slot_t  best_slot_next;
  logic   row_has_best_next;

  always_comb begin
    cur_dist = (item.distance == DIST_ONES) ? DIST_SAT : item.distance;
    col_m    = find_slot(cfg, item.column_index);
    self_m   = find_slot(cfg, item.row_index);
    take     = col_m.hit && (!row_has_best || cur_dist < best_distance ||
               (cur_dist == best_distance && col_m.slot < best_slot));
    best_distance_next = take ? cur_dist   : best_distance;
    best_slot_next     = take ? col_m.slot : best_slot;
    row_has_best_next  = take | row_has_best;

    sum.fire      = proc & item.row_end;
    sum.point     = item.row_index;
    sum.self_hit  = self_m.hit;
    sum.self_slot = self_m.slot;
    sum.has_best  = row_has_best_next;
    sum.best_slot = best_slot_next;
    sum.best_dist = best_distance_next;
    sum.pass_end  = item.pass_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= DIST_ONES;
      best_slot     <= '0;
      row_has_best  <= 1'b0;
    end else if (proc) begin
      if (item.row_end) begin
        best_distance <= DIST_ONES;
        best_slot     <= '0;
        row_has_best  <= 1'b0;
      end else begin
        best_distance <= best_distance_next;
        best_slot     <= best_slot_next;
        row_has_best  <= row_has_best_next;
      end
    end
  end
endmodule
`default_nettype wire

// File: design/nma_err_acc.sv
// nma_err_acc: per-slot and pass error sums with 48-bit saturation; forms
// the result word at the end of each row. Depends on nma_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nma_err_acc (
  input  wire logic         clk,
  input  wire logic         rst,
  input  nma_pkg::row_sum_t sum,
  output nma_pkg::res_t     res
);
  import nma_pkg::*;

  err_t [MAX_SLOTS-1:0] slot_err;
  err_t                 pass_total;

  logic               upd;
  slot_t              slot;
  dist_t              added;
  err_t               cur;
  logic [ERR_W:0]     slot_sum;
  logic [ERR_W:0]     tot_sum;
  err_t               slot_err_next;
  err_t               pass_total_next;

  always_comb begin
    upd      = !sum.self_hit && sum.has_best;
    slot     = sum.self_hit ? sum.self_slot : (sum.has_best ? sum.best_slot : '0);
    added    = upd ? sum.best_dist : '0;
    cur      = slot_err[slot];
    slot_sum = {1'b0, cur} + (ERR_W + 1)'(added);
    tot_sum  = {1'b0, pass_total} + (ERR_W + 1)'(added);
    slot_err_next   = slot_sum[ERR_W] ? ERR_MAX : slot_sum[ERR_W-1:0];
    pass_total_next = tot_sum[ERR_W]  ? ERR_MAX : tot_sum[ERR_W-1:0];

    res.point_index   = sum.point;
    res.assigned_slot = OUT_SLOT_W'(slot);
    res.added_error   = added;
    res.is_medoid     = sum.self_hit;
    res.slot_error    = slot_err_next;
    res.total_error   = pass_total_next;
    res.pass_done     = sum.pass_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_err   <= '0;
      pass_total <= '0;
    end else if (sum.fire) begin
      if (sum.pass_end) begin
        slot_err   <= '0;
        pass_total <= '0;
      end else if (upd) begin
        slot_err[slot] <= slot_err_next;
        pass_total     <= pass_total_next;
      end
    end
  end
endmodule
`default_nettype wire

// File: design/nearest_medoid_assign_top.sv
// Nearest-medoid assignment: one distance word accepted per cycle while the input is not stalled.
// Path: a row-ending word is accepted into the input register, then processed by
// the row minimum and error accumulator and its result loaded into the result register.
// Throughput: one word per cycle while the input is not stalled;
// input stalls only while a finished result waits on the output.
// Reset (synchronous, active high) empties both registers, clears row and error state.
`timescale 1ns / 1ps
`default_nettype none
module nearest_medoid_assign_top (
  input  wire logic   clk,
  input  wire logic   rst,
  nma_item_if.sink    items,
  nma_result_if.source results,
  nma_cfg_if.sink     cfg
);
  import nma_pkg::*;

  cfg_t     cfg_q;
  item_t    s1_item;
  logic     s1_valid;
  logic     s1_fire;
  row_sum_t row_sum;
  res_t     res_comb;
  res_t     res_q;
  logic     out_valid;

  nma_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_out (cfg_q)
  );

  nma_row_min u_row_min (
    .clk  (clk),
    .rst  (rst),
    .proc (s1_fire),
    .item (s1_item),
    .cfg  (cfg_q),
    .sum  (row_sum)
  );

  nma_err_acc u_err_acc (
    .clk (clk),
    .rst (rst),
    .sum (row_sum),
    .res (res_comb)
  );

  // A row-ending word needs room in the result register
  assign s1_fire     = s1_valid && (!s1_item.row_end || !out_valid || results.ready);
  assign items.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      s1_item.row_index    <= items.row_index;
      s1_item.column_index <= items.column_index;
      s1_item.distance     <= items.distance;
      s1_item.row_end      <= items.row_end;
      s1_item.pass_end     <= items.pass_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_item.row_end) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.row_end) begin
      res_q <= res_comb;
    end
  end

  assign results.valid         = out_valid;
  assign results.point_index   = res_q.point_index;
  assign results.assigned_slot = res_q.assigned_slot;
  assign results.added_error   = res_q.added_error;
  assign results.is_medoid     = res_q.is_medoid;
  assign results.slot_error    = res_q.slot_error;
  assign results.total_error   = res_q.total_error;
  assign results.pass_done     = res_q.pass_done;
endmodule
`default_nettype wire

// File: design/nma_checker.sv
// nma_checker: port-level checks on the nearest-medoid assignment top level,
// attached by bind. Depends on nma_pkg and nearest_medoid_assign_top.
`timescale 1ns / 1ps
`default_nettype none
module nma_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire nma_pkg::dist_t                 added_error,
  input wire logic                           is_medoid,
  input wire nma_pkg::err_t                  slot_error,
  input wire nma_pkg::err_t                  total_error
);
  import nma_pkg::*;

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // With no result waiting, input never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Stalled result holds its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(slot_error) &&
      $stable(total_error) && $stable(added_error))
    else $error("stalled result changed");

  // Pass total includes every slot sum
  a_total_ge: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> total_error >= slot_error)
    else $error("total error below slot error");

  // A medoid point adds nothing
  a_medoid_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && is_medoid |-> added_error == '0)
    else $error("medoid point added error");
endmodule

bind nearest_medoid_assign_top nma_checker u_nma_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (items.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .added_error (results.added_error),
  .is_medoid   (results.is_medoid),
  .slot_error  (results.slot_error),
  .total_error (results.total_error)
);
`default_nettype wire

// File: dv/nma_assign_check_pkg.sv
// Expected-assignment ledger for the nearest-medoid assignment block: tracks
// register writes, predicts one result per row end and checks arriving results.
// Depends on nma_pkg.
`timescale 1ns / 1ps
package nma_assign_check_pkg;
  import nma_pkg::*;

  class medoid_assignment_ledger;
    logic [NCL_W-1:0] cluster_count;
    idx_t             medoid [MAX_SLOTS];
    dist_t            best_dist;
    int unsigned      best_slot;
    bit               row_has_best;
    err_t             slot_err [MAX_SLOTS];
    err_t             pass_err;
    res_t             due_assignments [$];
    int unsigned      mismatches;

    function new();
      cluster_count = NCL_RESET;
      for (int s = 0; s < MAX_SLOTS; s++) begin
        medoid[s]   = idx_t'(s);
        slot_err[s] = '0;
      end
      pass_err   = '0;
      mismatches = 0;
      clear_row();
    endfunction

    function void clear_row();
      best_dist    = DIST_ONES;
      best_slot    = 0;
      row_has_best = 1'b0;
    endfunction

    function int unsigned slots_in_use();
      int unsigned n;
      n = int'(cluster_count);
      if (n == 0) n = 1;
      if (n > MAX_SLOTS) n = MAX_SLOTS;
      return n;
    endfunction

    function err_t add_clamped(err_t acc, dist_t d);
      logic [ERR_W:0] sum;
      sum = {1'b0, acc} + {{(ERR_W + 1 - DIST_W){1'b0}}, d};
      return sum[ERR_W] ? ERR_MAX : sum[ERR_W-1:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == REG_NUM_CLUSTERS)
        cluster_count = data[NCL_W-1:0];
      else if (index >= REG_MEDOID_BASE && index < REG_MEDOID_BASE + NUM_MEDOID_REGS)
        medoid[int'(index - REG_MEDOID_BASE)] = data[IDX_W-1:0];
    endfunction

    function void accept_word(item_t w);
      dist_t       d;
      int unsigned n;
      int unsigned slot;
      bit          found;
      bit          self;
      dist_t       added;
      res_t        r;
      d     = (w.distance == DIST_ONES) ? DIST_SAT : w.distance;
      n     = slots_in_use();
      found = 1'b0;
      for (int s = 0; s < MAX_SLOTS; s++) begin
        if (!found && s < n && medoid[s] == w.column_index) begin
          found = 1'b1;
          if (!row_has_best || d < best_dist || (d == best_dist && s < best_slot)) begin
            best_dist    = d;
            best_slot    = s;
            row_has_best = 1'b1;
          end
        end
      end
      if (!w.row_end) return;

      self = 1'b0;
      slot = 0;
      for (int s = 0; s < MAX_SLOTS; s++) begin
        if (!self && s < n && medoid[s] == w.row_index) begin
          self = 1'b1;
          slot = s;
        end
      end
      added = '0;
      if (!self && row_has_best) begin
        slot           = best_slot;
        added          = best_dist;
        slot_err[slot] = add_clamped(slot_err[slot], added);
        pass_err       = add_clamped(pass_err, added);
      end

      r.point_index   = w.row_index;
      r.assigned_slot = OUT_SLOT_W'(slot);
      r.added_error   = added;
      r.is_medoid     = self;
      r.slot_error    = slot_err[slot];
      r.total_error   = pass_err;
      r.pass_done     = w.pass_end;
      due_assignments = {due_assignments, r};

      clear_row();
      if (w.pass_end) begin
        for (int s = 0; s < MAX_SLOTS; s++) slot_err[s] = '0;
        pass_err = '0;
      end
    endfunction

    function void match_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        mismatches++;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      end
    endfunction

    function void check_assignment(res_t got);
      res_t want;
      if (due_assignments.size() == 0) begin
        mismatches++;
        $error("unexpected result word for point 0x%0h", got.point_index);
        return;
      end
      want = due_assignments.pop_front();
      match_field("point_index", want.point_index, got.point_index);
      match_field("assigned_slot", want.assigned_slot, got.assigned_slot);
      match_field("added_error", want.added_error, got.added_error);
      match_field("is_medoid", want.is_medoid, got.is_medoid);
      match_field("slot_error", want.slot_error, got.slot_error);
      match_field("total_error", want.total_error, got.total_error);
      match_field("pass_done", want.pass_done, got.pass_done);
    endfunction

    function int unsigned outstanding();
      return due_assignments.size();
    endfunction
  endclass

endpackage

// File: dv/tb_nearest_medoid_assign_top.sv
// Top of the nearest-medoid assignment testbench: clock, reset, word driver,
// result monitor, stalling receiver and the test sequence.
// Depends on nma_pkg, nma_ifs and nma_assign_check_pkg.
`timescale 1ns / 1ps
module tb_nearest_medoid_assign_top;
  import nma_pkg::*;
  import nma_assign_check_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_WORDS   = 160;
  localparam int unsigned MAX_DIST_ROWS = 20;
  localparam longint      TIMEOUT_NS    = 4_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nma_item_if   items_if ();
  nma_result_if results_if ();
  nma_cfg_if    cfg_if ();

  nearest_medoid_assign_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  medoid_assignment_ledger ledger = new();

  logic [NCL_W-1:0] cur_ncl = NCL_RESET;
  idx_t             cur_medoid [MAX_SLOTS];
  int unsigned      burst_left = 0;
  bit               tx_steady = 1'b0;
  bit               rx_steady = 1'b0;
  bit               long_hold_req = 1'b0;
  res_t             observed;

  initial begin
    items_if.valid        <= 1'b0;
    items_if.row_index    <= '0;
    items_if.column_index <= '0;
    items_if.distance     <= '0;
    items_if.row_end      <= 1'b0;
    items_if.pass_end     <= 1'b0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= '0;
    cfg_if.data           <= '0;
  end

  // Receiver: own stall pattern, with one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned seg_left;
    int unsigned seg_mode;
    logic        rdy;
    hold_left = 0;
    seg_left  = 0;
    seg_mode  = 0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
        rdy           = 1'b0;
      end else if (rx_steady) begin
        rdy = 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(4, 40);
        end
        seg_left--;
        case (seg_mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      results_if.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      observed.point_index   = results_if.point_index;
      observed.assigned_slot = results_if.assigned_slot;
      observed.added_error   = results_if.added_error;
      observed.is_medoid     = results_if.is_medoid;
      observed.slot_error    = results_if.slot_error;
      observed.total_error   = results_if.total_error;
      observed.pass_done     = results_if.pass_done;
      ledger.check_assignment(observed);
    end
  end

  task automatic send_item(item_t w);
    if (!tx_steady && burst_left == 0) begin
      items_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    items_if.valid        <= 1'b1;
    items_if.row_index    <= w.row_index;
    items_if.column_index <= w.column_index;
    items_if.distance     <= w.distance;
    items_if.row_end      <= w.row_end;
    items_if.pass_end     <= w.pass_end;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    ledger.accept_word(w);
  endtask

  task automatic send_fields(idx_t r, idx_t c, dist_t d, logic re, logic pe);
    item_t w;
    w.row_index    = r;
    w.column_index = c;
    w.distance     = d;
    w.row_end      = re;
    w.pass_end     = pe;
    send_item(w);
  endtask

  // Drop valid, wait for every due result, then let the pipeline empty
  task automatic settle();
    items_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers from cur_ncl / cur_medoid, valid held across words
  task automatic write_config();
    logic [CFG_DATA_W-1:0] word;
    logic [CFG_IDX_W-1:0]  idx;
    for (int r = 0; r <= NUM_MEDOID_REGS; r++) begin
      if (r == 0) begin
        idx  = REG_NUM_CLUSTERS;
        word = CFG_DATA_W'($urandom);
        word[NCL_W-1:0] = cur_ncl;
      end else begin
        idx  = REG_MEDOID_BASE + CFG_IDX_W'(r - 1);
        word = cur_medoid[r - 1];
      end
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= word;
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      ledger.write_reg(idx, word);
    end
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic idx_t pick_point();
    case ($urandom_range(0, 3))
      0, 1: return cur_medoid[$urandom_range(0, MAX_SLOTS - 1)];
      2: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return idx_t'($urandom);
    endcase
  endfunction

  function automatic idx_t pick_column();
    if ($urandom_range(0, 9) < 7) return cur_medoid[$urandom_range(0, MAX_SLOTS - 1)];
    return idx_t'($urandom);
  endfunction

  function automatic dist_t pick_distance();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DIST_ONES;
      2: return DIST_SAT;
      3, 4: return dist_t'($urandom_range(0, 3));
      default: return dist_t'($urandom);
    endcase
  endfunction

  function automatic void pick_config(int unsigned phase);
    case (phase)
      0: cur_ncl = NCL_W'(1);
      1: cur_ncl = NCL_W'(4);
      2: cur_ncl = NCL_W'(0);
      3: cur_ncl = NCL_W'(7);
      4: cur_ncl = NCL_W'(5);
      default: cur_ncl = NCL_W'($urandom_range(0, 7));
    endcase
    for (int s = 0; s < MAX_SLOTS; s++) begin
      case ($urandom_range(0, 5))
        0: cur_medoid[s] = '0;
        1: cur_medoid[s] = '1;
        2: cur_medoid[s] = (s > 0) ? cur_medoid[s - 1] : idx_t'($urandom);
        default: cur_medoid[s] = idx_t'($urandom);
      endcase
    end
  endfunction

  // Mostly well-formed rows over medoid columns, some raw noise words
  task automatic stream_rows(int unsigned words);
    int unsigned sent;
    int unsigned len;
    idx_t        point;
    bit          last;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(0, 9) == 0) begin
        send_fields(idx_t'($urandom), idx_t'($urandom), dist_t'($urandom),
                    1'($urandom), 1'($urandom));
        sent++;
      end else begin
        len   = $urandom_range(1, 6);
        point = pick_point();
        for (int e = 0; e < len; e++) begin
          last = (e == len - 1);
          send_fields((last && $urandom_range(0, 7) == 0) ? pick_point() : point,
                      pick_column(), pick_distance(), last,
                      last ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 7) == 0));
        end
        sent += len;
      end
    end
  endtask

  initial begin
    for (int s = 0; s < MAX_SLOTS; s++) cur_medoid[s] = idx_t'(s);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: two slots, medoids 0 and 1 active
    send_fields(10'd5, 10'd0, 32'd10, 1'b0, 1'b0);
    send_fields(10'd5, 10'd1, 32'd10, 1'b0, 1'b0);   // tie, lower slot holds
    send_fields(10'd5, 10'd2, 32'd1, 1'b1, 1'b0);    // inactive slot, no effect
    send_fields(10'd6, 10'd1, DIST_ONES, 1'b1, 1'b0);
    send_fields(10'd0, 10'd1, 32'd3, 1'b1, 1'b0);    // point is a medoid
    send_fields(10'd7, 10'd9, 32'd0, 1'b1, 1'b0);    // no medoid column
    send_fields(10'd8, 10'd0, 32'd0, 1'b0, 1'b1);    // pass_end alone is dropped
    send_fields(10'd8, 10'd1, 32'd0, 1'b1, 1'b1);
    settle();

    cur_ncl = NCL_W'(4);
    cur_medoid[0] = '1;
    cur_medoid[1] = '1;
    cur_medoid[2] = '0;
    cur_medoid[3] = 10'd512;
    write_config();
    send_fields('1, 10'd0, 32'd5, 1'b1, 1'b0);       // duplicate medoid, lowest slot
    send_fields(10'd100, '1, 32'd7, 1'b0, 1'b0);
    send_fields(10'd100, 10'd512, 32'd7, 1'b1, 1'b0);
    send_fields(10'd200, 10'd512, 32'd0, 1'b0, 1'b0);
    send_fields('1, 10'd0, 32'd1, 1'b1, 1'b0);       // last word decides medoid point
    send_fields(10'd300, 10'd0, DIST_ONES, 1'b0, 1'b0);
    send_fields(10'd300, 10'd512, DIST_SAT, 1'b1, 1'b1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      pick_config(p);
      write_config();
      tx_steady = (p == 6);
      if (p == 3) long_hold_req = 1'b1;
      stream_rows(PHASE_WORDS);
      settle();
    end

    // Back-to-back rows of the largest distance, no idling
    cur_ncl = NCL_W'(1);
    cur_medoid[0] = 10'd5;
    write_config();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (MAX_DIST_ROWS) send_fields(10'd7, 10'd5, DIST_ONES, 1'b1, 1'b0);
    send_fields(10'd7, 10'd5, DIST_ONES, 1'b1, 1'b1);
    settle();

    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("tb_nearest_medoid_assign_top: clean");
    end else begin
      $display("tb_nearest_medoid_assign_top: errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_nearest_medoid_assign_top: errors");
    $finish;
  end

endmodule

// File: nearest_medoid_assign_top.f
design/nma_pkg.sv
design/nma_ifs.sv
design/nma_cfg_regs.sv
design/nma_row_min.sv
design/nma_err_acc.sv
design/nearest_medoid_assign_top.sv
design/nma_checker.sv
dv/nma_assign_check_pkg.sv
dv/tb_nearest_medoid_assign_top.sv
